[src/wpm_pkg.sv]
// Package for the wildcard pattern matcher.
// Holds the request modes, the wildcard symbols, size limits and the cell control struct.
// Depends on nothing.
package wpm_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int LEN_MAX_W       = 13;

    typedef logic [1:0] t_mode;
    typedef logic [7:0] t_sym;

    localparam t_mode MODE_CLEAR  = 2'd0;
    localparam t_mode MODE_APPEND = 2'd1;
    localparam t_mode MODE_TEXT   = 2'd2;
    localparam t_mode MODE_END    = 2'd3;

    localparam t_sym SYM_ANY  = 8'd63;
    localparam t_sym SYM_STAR = 8'd42;

    typedef struct packed {
        logic                 restart;
        logic                 text;
        logic                 append;
        t_sym                 symbol;
        logic [LEN_MAX_W-1:0] len;
    } t_cell_ctrl;

endpackage

[src/wpm_if.sv]
// Handshake interfaces for the request and response channels.
// Depends on wpm_pkg.
interface wpm_in_if import wpm_pkg::*; ();
    logic  valid;
    logic  ready;
    t_mode mode;
    t_sym  symbol;

    modport source (output valid, output mode, output symbol, input ready);
    modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface wpm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic overflow;

    modport source (output valid, output matched, output overflow, input ready);
    modport sink   (input valid, input matched, input overflow, output ready);
endinterface

[src/wpm_cell.sv]
// One pattern position: holds its pattern byte and its active bit.
// Passes the star closure and the advance to the next position.
// Depends on wpm_pkg.
module wpm_cell import wpm_pkg::*; #(
    parameter int POS = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_chain,
    input  logic       i_adv,
    output logic       o_chain,
    output logic       o_adv,
    output logic       o_hit
);

    logic r_act;
    logic n_act;
    t_sym r_pat;
    logic w_in;
    logic w_close;
    logic w_star;
    logic w_match;

    assign w_in    = i_ctrl.len > LEN_MAX_W'(POS);
    assign w_close = r_act | i_chain;
    assign w_star  = r_pat == SYM_STAR;
    assign w_match = (r_pat == SYM_ANY) || (r_pat == i_ctrl.symbol);
    assign o_chain = w_close & w_in & w_star;
    assign o_adv   = w_close & w_in & !w_star & w_match;
    assign o_hit   = w_close & (i_ctrl.len == LEN_MAX_W'(POS));

    always_comb begin
        n_act = r_act;
        if (i_ctrl.restart) begin
            n_act = (POS == 0);
        end else if (i_ctrl.text) begin
            n_act = o_chain | i_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= (POS == 0);
        end else begin
            r_act <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.append && (i_ctrl.len == LEN_MAX_W'(POS))) begin
            r_pat <= i_ctrl.symbol;
        end
    end

endmodule

[src/wildcard_pattern_matcher.sv]
// Wildcard pattern matcher: a row of position cells with '?' and '*' support.
// The result is registered when the end-of-text request is accepted and shows in the cycle after.
// Throughput: one request per cycle; requests stall while a result waits and while reset is held.
// Reset (synchronous, active low): empty pattern, overflow clear, position zero active,
// and no request is taken while reset is held.
// Depends on wpm_pkg, wpm_if and wpm_cell.
module wildcard_pattern_matcher import wpm_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wpm_in_if.sink    i_req,
    wpm_out_if.source o_rsp
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     n_len;
    logic                 r_ovf;
    logic                 n_ovf;
    logic                 r_last;
    logic                 n_last;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_matched;
    logic                 r_overflow;
    logic                 w_take;
    logic                 w_full;
    logic                 w_last_close;
    t_cell_ctrl           w_ctrl;
    logic [MAX_PATTERN:0] w_chain;
    logic [MAX_PATTERN:0] w_adv;
    logic [MAX_PATTERN:0] w_hit;

    assign i_req.ready    = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign w_take         = i_req.valid && i_req.ready;
    assign w_full         = r_len == LEN_W'(MAX_PATTERN);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.matched  = r_matched;
    assign o_rsp.overflow = r_overflow;

    always_comb begin
        w_ctrl.restart = w_take && ((i_req.mode == MODE_CLEAR) || (i_req.mode == MODE_END));
        w_ctrl.text    = w_take && (i_req.mode == MODE_TEXT);
        w_ctrl.append  = w_take && (i_req.mode == MODE_APPEND) && !w_full;
        w_ctrl.symbol  = i_req.symbol;
        w_ctrl.len     = LEN_MAX_W'(r_len);
    end

    assign w_chain[0] = 1'b0;
    assign w_adv[0]   = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            wpm_cell #(
                .POS (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_chain (w_chain[g]),
                .i_adv   (w_adv[g]),
                .o_chain (w_chain[g+1]),
                .o_adv   (w_adv[g+1]),
                .o_hit   (w_hit[g])
            );
        end
    endgenerate

    assign w_last_close       = r_last | w_chain[MAX_PATTERN];
    assign w_hit[MAX_PATTERN] = w_last_close && w_full;

    always_comb begin
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_rsp.ready;
        if (w_take) begin
            unique case (i_req.mode)
                MODE_CLEAR: begin
                    n_len  = '0;
                    n_ovf  = 1'b0;
                    n_last = 1'b0;
                end
                MODE_APPEND: begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_len = r_len + LEN_W'(1);
                    end
                end
                MODE_TEXT: begin
                    n_last = w_adv[MAX_PATTERN];
                end
                MODE_END: begin
                    n_last      = 1'b0;
                    n_out_valid = 1'b1;
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && (i_req.mode == MODE_END)) begin
            r_matched  <= !r_ovf && (|w_hit);
            r_overflow <= r_ovf;
        end
    end

endmodule

[bench/wildcard_pattern_matcher_test.sv]
// Testbench for the wildcard pattern matcher: directed, overflow, random and back-pressure tests,
// checked against an in-bench bit-parallel model of the matcher.
// Depends on wpm_pkg, wpm_if and the wildcard_pattern_matcher RTL.
`timescale 1ns / 1ps

module wildcard_pattern_matcher_test;
    import wpm_pkg::*;

    localparam int   DEPTH       = MAX_PATTERN_DEF;
    localparam int   PHASE_ITEMS = 350;
    localparam int   HOLD_CYCLES = 300;
    localparam t_sym LIT_A       = 8'h61;
    localparam t_sym LIT_B       = 8'h62;
    localparam t_sym LIT_C       = 8'h63;

    typedef struct {
        logic matched;
        logic overflow;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    wpm_in_if  req_ch ();
    wpm_out_if rsp_ch ();

    wildcard_pattern_matcher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_sym           pat_mem [DEPTH];
    int             pat_len;
    logic [DEPTH:0] live;
    logic           ovf_seen;
    t_verdict       expected_verdicts [$];

    int error_count   = 0;
    int sent_count    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    function automatic void close_stars();
        for (int j = 0; j < pat_len; j++) begin
            if (live[j] && pat_mem[j] == SYM_STAR) live[j + 1] = 1'b1;
        end
    endfunction

    function automatic void predict_match(t_mode m, t_sym s);
        logic [DEPTH:0] nxt;
        t_verdict       v;
        case (m)
            MODE_CLEAR: begin
                pat_len  = 0;
                ovf_seen = 1'b0;
                live     = {{DEPTH{1'b0}}, 1'b1};
            end
            MODE_APPEND: begin
                if (pat_len < DEPTH) begin
                    pat_mem[pat_len] = s;
                    pat_len++;
                end else begin
                    ovf_seen = 1'b1;
                end
            end
            MODE_TEXT: begin
                close_stars();
                nxt = '0;
                for (int j = 0; j < pat_len; j++) begin
                    if (live[j]) begin
                        if (pat_mem[j] == SYM_STAR) nxt[j] = 1'b1;
                        else if (pat_mem[j] == SYM_ANY || pat_mem[j] == s) nxt[j + 1] = 1'b1;
                    end
                end
                live = nxt;
            end
            default: begin
                close_stars();
                v.overflow = ovf_seen;
                v.matched  = ovf_seen ? 1'b0 : live[pat_len];
                expected_verdicts.push_back(v);
                live = {{DEPTH{1'b0}}, 1'b1};
            end
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < 50) $display("%0t ns: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    initial begin
        t_verdict exp_v;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result matched=%b overflow=%b",
                                              rsp_ch.matched, rsp_ch.overflow));
                end else begin
                    exp_v = expected_verdicts.pop_front();
                    if (rsp_ch.matched !== exp_v.matched)
                        report_mismatch($sformatf("matched %b, expected %b",
                                                  rsp_ch.matched, exp_v.matched));
                    if (rsp_ch.overflow !== exp_v.overflow)
                        report_mismatch($sformatf("overflow %b, expected %b",
                                                  rsp_ch.overflow, exp_v.overflow));
                end
            end
            if (!i_rst_n) begin
                rsp_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_request(t_mode m, t_sym s);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.mode   <= m;
        req_ch.symbol <= s;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_match(m, s);
        sent_count++;
    endtask

    function automatic t_sym pick_symbol();
        case ($urandom_range(9))
            0, 1:    return t_sym'($urandom_range(255));
            2:       return SYM_ANY;
            3:       return SYM_STAR;
            4, 5, 6: return LIT_A;
            default: return LIT_B;
        endcase
    endfunction

    // Builds a text that fits the pattern, optionally spoiled by one edit, then ends it.
    task automatic send_text_for(t_sym pat[$], bit spoil);
        t_sym txt [$];
        int   k;
        foreach (pat[i]) begin
            if (pat[i] == SYM_STAR) repeat ($urandom_range(3)) txt.push_back(pick_symbol());
            else if (pat[i] == SYM_ANY) txt.push_back(pick_symbol());
            else txt.push_back(pat[i]);
        end
        if (spoil && txt.size() > 0) begin
            k = $urandom_range(txt.size() - 1);
            case ($urandom_range(2))
                0:       txt[k] = pick_symbol();
                1:       txt.delete(k);
                default: txt.insert(k, pick_symbol());
            endcase
        end else if (spoil) begin
            txt.push_back(pick_symbol());
        end
        foreach (txt[i]) send_request(MODE_TEXT, txt[i]);
        send_request(MODE_END, t_sym'($urandom_range(255)));
    endtask

    task automatic apply_reset();
        i_rst_n       <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.mode   <= MODE_CLEAR;
        req_ch.symbol <= '0;
        pat_len  = 0;
        ovf_seen = 1'b0;
        live     = {{DEPTH{1'b0}}, 1'b1};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_directed();
        send_request(MODE_END, 8'hFF);
        send_request(MODE_TEXT, LIT_A);
        send_request(MODE_END, 8'h00);
        send_request(MODE_APPEND, SYM_STAR);
        send_request(MODE_END, 8'h00);
        send_request(MODE_TEXT, 8'h00);
        send_request(MODE_TEXT, 8'hFF);
        send_request(MODE_END, 8'h55);
        send_request(MODE_CLEAR, 8'hFF);
        send_request(MODE_APPEND, LIT_A);
        send_request(MODE_APPEND, SYM_ANY);
        send_request(MODE_APPEND, LIT_C);
        send_request(MODE_TEXT, LIT_A);
        send_request(MODE_TEXT, SYM_ANY);
        send_request(MODE_TEXT, LIT_C);
        send_request(MODE_END, 8'hAA);
        send_request(MODE_TEXT, SYM_STAR);
        send_request(MODE_TEXT, LIT_B);
        send_request(MODE_TEXT, LIT_C);
        send_request(MODE_END, 8'h00);
        send_request(MODE_TEXT, LIT_A);
        send_request(MODE_APPEND, SYM_STAR);
        send_request(MODE_TEXT, LIT_B);
        send_request(MODE_TEXT, LIT_C);
        send_request(MODE_END, 8'h00);
    endtask

    task automatic test_overflow();
        send_request(MODE_CLEAR, 8'h00);
        repeat (DEPTH - 1) send_request(MODE_APPEND, SYM_STAR);
        send_request(MODE_APPEND, 8'hFF);
        send_request(MODE_TEXT, 8'hFF);
        send_request(MODE_END, 8'h00);
        send_request(MODE_APPEND, LIT_A);
        send_request(MODE_TEXT, 8'hFF);
        send_request(MODE_END, 8'h00);
        send_request(MODE_APPEND, LIT_B);
        send_request(MODE_END, 8'h00);
        send_request(MODE_CLEAR, 8'h00);
        send_request(MODE_END, 8'h00);
    endtask

    task automatic test_random(int items);
        t_sym pat_q [$];
        int   start;
        int   len;
        start = sent_count;
        while (sent_count - start < items) begin
            if ($urandom_range(99) < 85) begin
                pat_q.delete();
                send_request(MODE_CLEAR, t_sym'($urandom_range(255)));
                len = ($urandom_range(99) < 4) ? $urandom_range(DEPTH - 4, DEPTH + 6)
                                               : $urandom_range(8);
                repeat (len) begin
                    pat_q.push_back(pick_symbol());
                    send_request(MODE_APPEND, pat_q[$]);
                end
                repeat ($urandom_range(1, 3)) send_text_for(pat_q, $urandom_range(99) < 30);
            end else begin
                repeat ($urandom_range(1, 5))
                    send_request(t_mode'($urandom_range(3)), t_sym'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_backpressure();
        t_sym pat_q [$];
        pat_q = '{LIT_A, SYM_STAR, SYM_ANY};
        hold_left = HOLD_CYCLES;
        send_request(MODE_CLEAR, 8'h00);
        foreach (pat_q[i]) send_request(MODE_APPEND, pat_q[i]);
        repeat (12) send_text_for(pat_q, $urandom_range(1) == 1);
    endtask

    initial begin
        apply_reset();
        send_idle_pct = 33;
        recv_idle_pct = 57;
        test_directed();
        test_overflow();
        test_random(PHASE_ITEMS);
        send_idle_pct = 57;
        recv_idle_pct = 33;
        test_random(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(PHASE_ITEMS);
        test_backpressure();
        req_ch.valid <= 1'b0;
        while (expected_verdicts.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/wpm_pkg.sv
src/wpm_if.sv
src/wpm_cell.sv
src/wildcard_pattern_matcher.sv
bench/wildcard_pattern_matcher_test.sv
